// ----- rtl/bda_pkg.sv -----
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and character constants for the decimal text converter.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int CODE_WIDTH = 6;

    localparam logic [CODE_WIDTH-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CODE_WIDTH-1:0] CHAR_MINUS = 6'd45;

    typedef struct packed {
        logic load;
        logic convert;
        logic shift_digit;
    } bda_ctrl_t;

endpackage

// ----- rtl/bda_dabble.sv -----
// ----------------------------------------------------------------------------
// bda_dabble
// Shift-and-add-3 binary to BCD register, one binary bit per cycle; the BCD
// register then shifts out one digit per cycle, most significant first.
// ----------------------------------------------------------------------------
module bda_dabble #(
    parameter int NUMBER_WIDTH = 64,
    parameter int NDIG         = 20
) (
    input  logic                    clk,
    input  bda_pkg::bda_ctrl_t      ctrl,
    input  logic [NUMBER_WIDTH-1:0] mag_in,
    output logic [3:0]              top_digit
);

    localparam int BCD_WIDTH = NDIG * 4;

    logic [NUMBER_WIDTH-1:0] bin_reg;
    logic [BCD_WIDTH-1:0]    bcd_reg;
    logic [BCD_WIDTH-1:0]    bcd_adj;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            bin_reg <= mag_in;
            bcd_reg <= '0;
        end
        else if (ctrl.convert)
        begin
            bin_reg <= {bin_reg[NUMBER_WIDTH-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_WIDTH-2:0], bin_reg[NUMBER_WIDTH-1]};
        end
        else if (ctrl.shift_digit)
        begin
            bcd_reg <= {bcd_reg[BCD_WIDTH-5:0], 4'd0};
        end
    end

    assign top_digit = bcd_reg[BCD_WIDTH-1 -: 4];

endmodule

// ----- rtl/binary_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts one integer to its decimal ASCII text, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   An item (number_bits, func) is taken at a clock edge with start high and
//   busy low. func = 0 reads the low NUMBER_WIDTH bits as two's complement,
//   func = 1 as unsigned. Characters leave on ascii_code/last, each valid for
//   exactly one cycle while strobe is high; last marks the final character.
//   A negative value is led by '-'; leading zeros are dropped, zero gives "0".
// Timing:
//   The shift-and-add-3 register takes one binary bit per cycle over all
//   NUMBER_WIDTH bits. Then '-' (if negative) is sent and the digit register
//   shifts one digit per cycle over all NDIG digit places, leading zeros
//   silently. busy stays high from the accepted item until the last digit
//   place has been shifted; no new item is taken before then. Each character
//   is registered and appears in the cycle after it is formed. The receiver
//   cannot stall; characters are never held.
// Reset:
//   rst_n clears the sequencer and strobe; the block comes up idle.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii #(
    parameter int NUMBER_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] number_bits,
    input  logic        func,
    output logic        strobe,
    output logic [5:0]  ascii_code,
    output logic        last
);

    localparam int NDIG = (NUMBER_WIDTH * 30103) / 100000 + 1;
    localparam int CW   = $clog2(NUMBER_WIDTH);
    localparam int DW   = $clog2(NDIG + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CONV   = 2'd1;
    localparam logic [1:0] ST_SIGN   = 2'd2;
    localparam logic [1:0] ST_DIGITS = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DW-1:0] dig_cnt_reg, dig_cnt_next;
    logic          neg_reg, neg_next;
    logic          started_reg, started_next;
    logic          strobe_reg, strobe_next;
    logic [5:0]    ascii_reg, ascii_next;
    logic          last_reg, last_next;

    logic [NUMBER_WIDTH-1:0] value;
    logic [NUMBER_WIDTH-1:0] mag;
    logic                    accept;
    logic                    neg_in;
    logic [3:0]              top_digit;
    bda_pkg::bda_ctrl_t      ctrl;

    assign accept = start && (state_reg == ST_IDLE);
    assign value  = number_bits[NUMBER_WIDTH-1:0];
    assign neg_in = !func && value[NUMBER_WIDTH-1];
    assign mag    = neg_in ? (~value + 1'b1) : value;

    bda_dabble #(
        .NUMBER_WIDTH(NUMBER_WIDTH),
        .NDIG        (NDIG)
    ) u_dabble (
        .clk      (clk),
        .ctrl     (ctrl),
        .mag_in   (mag),
        .top_digit(top_digit)
    );

    always_comb
    begin
        state_next       = state_reg;
        bit_cnt_next     = bit_cnt_reg;
        dig_cnt_next     = dig_cnt_reg;
        neg_next         = neg_reg;
        started_next     = started_reg;
        strobe_next      = 1'b0;
        ascii_next       = ascii_reg;
        last_next        = last_reg;
        ctrl.load        = 1'b0;
        ctrl.convert     = 1'b0;
        ctrl.shift_digit = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load    = 1'b1;
                    neg_next     = neg_in;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.convert = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == CW'(NUMBER_WIDTH - 1))
                begin
                    dig_cnt_next = DW'(NDIG);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                ascii_next  = bda_pkg::CHAR_MINUS;
                last_next   = 1'b0;
                state_next  = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                ctrl.shift_digit = 1'b1;
                dig_cnt_next     = dig_cnt_reg - 1'b1;
                if (started_reg || top_digit != 4'd0 || dig_cnt_reg == DW'(1))
                begin
                    strobe_next  = 1'b1;
                    ascii_next   = bda_pkg::CHAR_ZERO | {2'b00, top_digit};
                    last_next    = (dig_cnt_reg == DW'(1));
                    started_next = 1'b1;
                end
                if (dig_cnt_reg == DW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        started_reg <= started_next;
        ascii_reg   <= ascii_next;
        last_reg    <= last_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign ascii_code = ascii_reg;
    assign last       = last_reg;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for binary_to_decimal_ascii (64-bit integer to decimal text).
// A short table of directed numbers covers zero, both signedness modes, the
// signed and unsigned extremes, powers of ten and alternating bit patterns.
// Random numbers follow: full-width patterns, values of random bit length,
// values next to powers of ten and to zero, all-ones or the signed extremes.
// Each accepted number is turned into its expected characters, which are
// matched in order against the strobed output. Number submission pauses in
// random bursts, some while the converter is busy and some after it is idle.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FN_SIGNED   = 1'b0;
    localparam logic FN_UNSIGNED = 1'b1;

    localparam int N_RANDOM       = 130;
    localparam int QUIET_TAIL     = 30;
    localparam int MAX_CHARS      = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int N_DIR          = 20;

    typedef struct packed {
        logic [bda_pkg::CODE_WIDTH-1:0] code;
        logic                           last;
    } text_char_t;

    typedef struct {
        logic [63:0] value;
        logic        fn;
        string       text;
    } dir_row_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic [63:0] number_bits = '0;
    logic        func        = FN_SIGNED;
    logic        strobe;
    logic [5:0]  ascii_code;
    logic        last;

    text_char_t expected_text[$];

    int errors        = 0;
    int chars_checked = 0;
    int numbers_sent  = 0;
    int n_unsigned    = 0;
    int n_negative    = 0;
    int idle_cycles   = 0;

    // empty text: expected characters come from the predictor
    dir_row_t dir_rows [N_DIR] = '{
        '{64'd0,                     FN_SIGNED,   "0"},
        '{64'd0,                     FN_UNSIGNED, "0"},
        '{64'd1,                     FN_SIGNED,   "1"},
        '{64'd9,                     FN_UNSIGNED, "9"},
        '{64'd10,                    FN_SIGNED,   "10"},
        '{64'hFFFF_FFFF_FFFF_FFFF,   FN_SIGNED,   "-1"},
        '{64'hFFFF_FFFF_FFFF_FFFF,   FN_UNSIGNED, "18446744073709551615"},
        '{64'h8000_0000_0000_0000,   FN_SIGNED,   "-9223372036854775808"},
        '{64'h8000_0000_0000_0000,   FN_UNSIGNED, "9223372036854775808"},
        '{64'h7FFF_FFFF_FFFF_FFFF,   FN_SIGNED,   "9223372036854775807"},
        '{64'h7FFF_FFFF_FFFF_FFFF,   FN_UNSIGNED, "9223372036854775807"},
        '{64'd10000000000000000000,  FN_UNSIGNED, "10000000000000000000"},
        '{64'd9999999999999999999,   FN_UNSIGNED, "9999999999999999999"},
        '{64'hFFFF_FFFF_FFFF_FFF6,   FN_SIGNED,   "-10"},
        '{64'h8000_0000_0000_0001,   FN_SIGNED,   "-9223372036854775807"},
        '{64'h0123_4567_89AB_CDEF,   FN_SIGNED,   ""},
        '{64'hFEDC_BA98_7654_3210,   FN_SIGNED,   ""},
        '{64'hFEDC_BA98_7654_3210,   FN_UNSIGNED, ""},
        '{64'hAAAA_AAAA_AAAA_AAAA,   FN_UNSIGNED, ""},
        '{64'h5555_5555_5555_5555,   FN_SIGNED,   ""}
    };

    binary_to_decimal_ascii #(
        .NUMBER_WIDTH(64)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .number_bits(number_bits),
        .func       (func),
        .strobe     (strobe),
        .ascii_code (ascii_code),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void predict_text(input logic [63:0] value, input logic fn);
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digs [MAX_CHARS];
        int          nd;
        int          k;
        neg = (fn == FN_SIGNED) && value[63];
        mag = neg ? -value : value;
        nd  = 0;
        do
        begin
            digs[nd] = 4'(mag % 64'd10);
            mag      = mag / 64'd10;
            nd++;
        end
        while (mag != 0 && nd < MAX_CHARS);
        if (neg)
            expected_text.push_back('{bda_pkg::CHAR_MINUS, 1'b0});
        for (k = nd - 1; k >= 0; k--)
            expected_text.push_back('{bda_pkg::CHAR_ZERO + bda_pkg::CODE_WIDTH'(digs[k]),
                                      k == 0});
    endfunction

    function automatic void push_literal(input string s);
        int  k;
        byte ch;
        for (k = 0; k < s.len(); k++)
        begin
            ch = s[k];
            expected_text.push_back('{ch[bda_pkg::CODE_WIDTH-1:0], k == s.len() - 1});
        end
    endfunction

    task automatic send_number(input logic [63:0] value, input logic fn,
                               input string text, input bit allow_idle);
        int gap;
        if (allow_idle && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1)
            begin
                @(posedge clk);
                while (busy)
                    @(posedge clk);
            end
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        number_bits <= value;
        func        <= fn;
        do
            @(posedge clk);
        while (busy);
        if (text.len() != 0)
            push_literal(text);
        else
            predict_text(value, fn);
        numbers_sent++;
        if (fn == FN_UNSIGNED)
            n_unsigned++;
        else if (value[63])
            n_negative++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        text_char_t exp_c;
        if (rst_n && strobe)
        begin
            if (expected_text.size() == 0)
            begin
                if (errors < 10)
                    $display("ERROR: unexpected char code=%0d last=%0b", ascii_code, last);
                errors++;
            end
            else
            begin
                exp_c = expected_text.pop_front();
                chars_checked++;
                if (ascii_code !== exp_c.code)
                begin
                    if (errors < 10)
                        $display("ERROR: char %0d ascii_code exp %0d got %0d",
                                 chars_checked, exp_c.code, ascii_code);
                    errors++;
                end
                if (last !== exp_c.last)
                begin
                    if (errors < 10)
                        $display("ERROR: char %0d last exp %0b got %0b",
                                 chars_checked, exp_c.last, last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: watchdog expired, %0d chars outstanding",
                     expected_text.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] value;
        logic [63:0] pow10;
        logic        fn;
        int          i;
        int          nbits;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIR; i++)
            send_number(dir_rows[i].value, dir_rows[i].fn, dir_rows[i].text, 1'b1);

        for (i = 0; i < N_RANDOM; i++)
        begin
            fn    = 1'($urandom_range(0, 1));
            value = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: ;
                1:
                begin
                    nbits = $urandom_range(1, 64);
                    value = value >> (64 - nbits);
                    if ($urandom_range(0, 1) == 1)
                        value = -value;
                end
                2:
                begin
                    pow10 = 64'd1;
                    repeat ($urandom_range(0, 19)) pow10 = pow10 * 64'd10;
                    value = pow10 + 64'($urandom_range(0, 2)) - 64'd1;
                    if ($urandom_range(0, 2) == 0)
                        value = -value;
                end
                default:
                    value = {1'($urandom_range(0, 1)), 59'd0, 4'($urandom)}
                            ^ {64{$urandom_range(0, 1) == 1}};
            endcase
            send_number(value, fn, "", i < N_RANDOM - QUIET_TAIL);
        end
        start <= 1'b0;

        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d numbers (%0d unsigned, %0d negative signed), %0d chars checked",
                 numbers_sent, n_unsigned, n_negative, chars_checked);
        $display("Mismatches: %0d", errors);
        if (errors == 0 && expected_text.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
